### design/assert_macros.svh
// Assertion macros shared by the encoder poller modules.
// Needs nothing else; included by each file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, switched off during reset.
`define AESP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aesp assertion failed");

// Implication checked in the following cycle, switched off during reset.
`define AESP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aesp assertion failed");

`endif

### design/aesp_pkg.sv
// Types and constants for the absolute encoder SPI poller.
// No dependencies; used by the sequencer, the output buffer and the top level.
package aesp_pkg;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_ZERO = 2'd1;
  localparam logic [1:0] OP_BYTE = 2'd2;

  localparam logic [7:0] CMD_READ = 8'h10;
  localparam logic [7:0] CMD_ZERO = 8'h70;
  localparam logic [7:0] ACK_ZERO = 8'h80;
  localparam logic [7:0] NOP_BYTE = 8'h00;

  localparam logic [9:0] POLL_LIMIT_RESET = 10'd100;

  // 360/4096 degrees per count in Q9.7 is pos * 360 >> 5.
  localparam logic [20:0] DEG_SCALE = 21'd360;
  localparam int unsigned DEG_SHIFT = 5;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FIRST = 3'd1,
    PH_POLL  = 3'd2,
    PH_MSB   = 3'd3,
    PH_LSB   = 3'd4
  } phase_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic        status;
    logic [11:0] position;
    logic [15:0] degrees_q7;
  } result_t;

endpackage

### design/aesp_cmd_if.sv
// Input channel of the encoder poller: command or received byte per word.
// Depends on nothing but the handshake convention valid and ready.
interface aesp_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

### design/aesp_rsp_if.sv
// Output channel of the encoder poller: one result word per input word.
// Depends on nothing but the handshake convention valid and ready.
interface aesp_rsp_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        done_res;
  logic        status;
  logic [11:0] position;
  logic [15:0] degrees_q7;

  modport source (output valid, output tx_valid, output tx_byte, output done_res,
                  output status, output position, output degrees_q7, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input done_res,
                input status, input position, input degrees_q7, output ready);
endinterface

### design/aesp_seq.sv
// Command sequencer: phase state machine and result computation for one word.
// Uses aesp_pkg and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module aesp_seq
  import aesp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  input  logic       accept,
  input  logic [1:0] opcode,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic        zero_mode, zero_mode_next;
  logic [9:0]  poll_count, poll_count_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [9:0]  poll_limit;

  logic        busy;
  logic        reply_match;
  logic        poll_expired;
  logic [11:0] pos;
  logic [20:0] deg_full;

  assign busy         = (phase != PH_IDLE);
  assign reply_match  = (rx_byte == (zero_mode ? ACK_ZERO : CMD_READ));
  assign poll_expired = (poll_count >= poll_limit);
  assign pos          = {high_nibble, rx_byte};
  assign deg_full     = {9'd0, pos} * DEG_SCALE;

  always_comb begin
    phase_next       = phase;
    zero_mode_next   = zero_mode;
    poll_count_next  = poll_count;
    high_nibble_next = high_nibble;
    if (accept) begin
      case (opcode)
        OP_READ, OP_ZERO: begin
          if (!busy) begin
            zero_mode_next   = opcode[0];
            poll_count_next  = '0;
            high_nibble_next = '0;
            phase_next       = PH_FIRST;
          end
        end
        OP_BYTE: begin
          unique case (phase)
            PH_FIRST: phase_next = PH_POLL;
            PH_POLL: begin
              if (reply_match) begin
                phase_next = zero_mode ? PH_IDLE : PH_MSB;
              end else if (poll_expired) begin
                phase_next = PH_IDLE;
              end else begin
                poll_count_next = poll_count + 10'd1;
              end
            end
            PH_MSB: begin
              high_nibble_next = rx_byte[3:0];
              phase_next       = PH_LSB;
            end
            PH_LSB:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res = '0;
    case (opcode)
      OP_READ, OP_ZERO: begin
        if (!busy) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = opcode[0] ? CMD_ZERO : CMD_READ;
        end
      end
      OP_BYTE: begin
        unique case (phase)
          PH_FIRST, PH_MSB: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = NOP_BYTE;
          end
          PH_POLL: begin
            if (reply_match && zero_mode) begin
              res.done_res = 1'b1;
            end else if (reply_match || !poll_expired) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = NOP_BYTE;
            end else begin
              res.done_res = 1'b1;
              res.status   = 1'b1;
            end
          end
          PH_LSB: begin
            res.done_res   = 1'b1;
            res.position   = pos;
            res.degrees_q7 = deg_full[DEG_SHIFT +: 16];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      zero_mode   <= 1'b0;
      poll_count  <= '0;
      high_nibble <= '0;
      poll_limit  <= POLL_LIMIT_RESET;
    end else begin
      phase       <= phase_next;
      zero_mode   <= zero_mode_next;
      poll_count  <= poll_count_next;
      high_nibble <= high_nibble_next;
      if (cfg_we) begin
        poll_limit <= cfg_data;
      end
    end
  end

  // A finished command always leaves the sequencer idle.
  `AESP_ASSERT_NXT(a_done_goes_idle, clk, rst, accept && res.done_res, phase == PH_IDLE)
  // The poll counter only advances while it is still below the configured limit.
  `AESP_ASSERT_IMP(a_poll_bounded, clk, rst, phase == PH_POLL && poll_count_next != poll_count,
                   poll_count < poll_limit)
  // A start word only moves an idle sequencer into the first-reply phase.
  `AESP_ASSERT_NXT(a_start_idle, clk, rst,
                   accept && !busy && (opcode == OP_READ || opcode == OP_ZERO),
                   phase == PH_FIRST)

endmodule

### design/aesp_obuf.sv
// Two-entry output buffer: result register plus skid register for stalls.
// Uses aesp_pkg for the result word and assert_macros.svh for checks.
`include "assert_macros.svh"

module aesp_obuf
  import aesp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    o_valid, s_valid;
  result_t o_data, s_data;
  logic    pop;

  assign pop        = o_valid && out_ready;
  assign push_ready = !s_valid;
  assign out_valid  = o_valid;
  assign out_data   = o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (pop) begin
      if (s_valid) begin
        s_valid <= 1'b0;
      end else if (!push) begin
        o_valid <= 1'b0;
      end
    end else if (push) begin
      if (!o_valid) begin
        o_valid <= 1'b1;
      end else begin
        s_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (s_valid) begin
        o_data <= s_data;
      end else if (push) begin
        o_data <= push_data;
      end
    end else if (push) begin
      if (!o_valid) begin
        o_data <= push_data;
      end else begin
        s_data <= push_data;
      end
    end
  end

  // The skid register is only ever filled behind a waiting result.
  `AESP_ASSERT_IMP(a_skid_behind, clk, rst, s_valid, o_valid)
  // A full buffer that is not drained stays full.
  `AESP_ASSERT_NXT(a_full_holds, clk, rst, s_valid && !out_ready, s_valid && o_valid)
  // A word pushed into an empty buffer is on the output next cycle.
  `AESP_ASSERT_NXT(a_push_shows, clk, rst, push && !o_valid, o_valid)

endmodule

### design/absolute_encoder_spi_poller_top.sv
// Absolute encoder SPI poller: one result word for every accepted input word.
// The sequencer update is a single registered step, then the result is buffered.
// Throughput: one word per cycle while the output buffer is not full.
// A two-entry output buffer keeps cmd ready through a stall on rsp until full.
// Reset (synchronous, active high) idles the sequencer and sets poll_limit to 100.
module absolute_encoder_spi_poller_top
  import aesp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  aesp_cmd_if.sink   cmd,
  aesp_rsp_if.source rsp
);

  logic    accept;
  logic    buf_ready;
  result_t seq_res;
  result_t out_word;

  assign cmd.ready = buf_ready;
  assign accept    = cmd.valid && buf_ready;

  aesp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .opcode   (cmd.opcode),
    .rx_byte  (cmd.rx_byte),
    .res      (seq_res)
  );

  aesp_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (seq_res),
    .push_ready (buf_ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_data   (out_word)
  );

  assign rsp.tx_valid   = out_word.tx_valid;
  assign rsp.tx_byte    = out_word.tx_byte;
  assign rsp.done_res   = out_word.done_res;
  assign rsp.status     = out_word.status;
  assign rsp.position   = out_word.position;
  assign rsp.degrees_q7 = out_word.degrees_q7;

endmodule
